// ===== rtl/brightness_piecewise_linear_map_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the brightness map unit checker
// ----------------------------------------------------------------------------
`ifndef BRIGHTNESS_PIECEWISE_LINEAR_MAP_UNIT_MACROS_SVH
`define BRIGHTNESS_PIECEWISE_LINEAR_MAP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BPLM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BPLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bplm_pkg.sv =====
// ----------------------------------------------------------------------------
// bplm_pkg
// Shared widths, defaults and register codes of the brightness map unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bplm_pkg;

    // Field widths
    localparam int BRI_W      = 16;
    localparam int LVL_W      = 16;
    localparam int POINT_W    = BRI_W + LVL_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Divider: 32-bit dividend, 16-bit divisor, quotient known to fit 16 bits
    localparam int DIVIDEND_W = 2 * LVL_W;
    localparam int DIVISOR_W  = BRI_W;
    localparam int QUO_W      = LVL_W;

    // Breakpoint table depth
    localparam int NUM_POINTS_DEF = 5;
    localparam int NUM_POINT_REGS = 5;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINT_OFF     = 3'd0,
        REG_POINT_MIN     = 3'd1,
        REG_POINT_DIM     = 3'd2,
        REG_POINT_DEFAULT = 3'd3,
        REG_POINT_MAX     = 3'd4,
        REG_OUTDOOR_TUNE  = 3'd5,
        REG_HBM_MODE      = 3'd6
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/bplm_div.sv =====
// ----------------------------------------------------------------------------
// bplm_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits QUO_W bits (upper dividend half below the divisor).
// ----------------------------------------------------------------------------
`default_nettype none

module bplm_div
    import bplm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic      [QUO_W-1:0]      quotient,
    output logic                       done
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [QUO_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   quo_reg;

    logic [QUO_W:0]     shifted;
    logic [QUO_W+1:0]   trial;
    logic               fits;

    // One restoring step: shift in next dividend bit, try the subtract
    assign shifted = {rem_reg, quo_reg[QUO_W-1]};
    assign trial   = {1'b0, shifted} - {{(QUO_W+2-DIVISOR_W){1'b0}}, divisor};
    assign fits    = ~trial[QUO_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
                rem_reg  <= dividend[DIVIDEND_W-1:QUO_W];
                quo_reg  <= dividend[QUO_W-1:0];
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? trial[QUO_W-1:0] : shifted[QUO_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], fits};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// ===== rtl/brightness_piecewise_linear_map_unit.sv =====
// ----------------------------------------------------------------------------
// brightness_piecewise_linear_map_unit
// Maps a requested brightness onto a panel tune level through a table of
// breakpoints with linear interpolation between them.
// s_axis carries one request: tdata = brightness, tuser = display_on.
// m_axis carries one result per request: tdata = tune level,
// tuser[0] = status (1: above top breakpoint), tuser[1] = write_panel.
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user must
// write them only while idle, as the block itself does not enforce it.
// A request walks the table one entry per cycle, then takes a multiply step
// and a restoring divide in bplm_div. Direct hits, the high-brightness shortcut
// and out-of-range requests finish without the multiply and divide. One request
// is in flight at a time; the input is ready again from the edge that loads the result.
// Reset clears all registers, the stored last tune level and both channels.
// Stall: a result holds on m_axis until taken. A new request can be accepted
// and processed meanwhile; it waits in its final step until the output frees.
// ----------------------------------------------------------------------------
`default_nettype none

module brightness_piecewise_linear_map_unit
    import bplm_pkg::*;
#(
    parameter int NUM_POINTS = NUM_POINTS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Request stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [BRI_W-1:0]      s_axis_tdata,   // [15:0] brightness
    input  wire logic                  s_axis_tuser,   // [0] display_on
    // Result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [LVL_W-1:0]      m_axis_tdata,   // [15:0] panel level
    output logic      [1:0]            m_axis_tuser,   // [0] status, [1] write_panel
    // Configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W     = $clog2(NUM_POINTS);
    localparam int TOP       = NUM_POINT_REGS - 1;
    localparam int REG_IDX_W = $clog2(NUM_POINT_REGS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    // Configuration registers
    logic [POINT_W-1:0] point_reg [NUM_POINT_REGS];
    logic [LVL_W-1:0]   outdoor_tune_reg;
    logic               hbm_mode_reg;

    // Sequencer and datapath registers
    state_t             state_reg;
    logic [BRI_W-1:0]   b_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [POINT_W-1:0] prev_reg;
    logic [LVL_W-1:0]   hi_lvl_reg;
    logic [BRI_W-1:0]   mul_a_reg;
    logic [LVL_W-1:0]   mag_reg;
    logic               neg_reg;
    logic [BRI_W-1:0]   den_reg;
    logic [DIVIDEND_W-1:0] prod_reg;
    logic               div_start_reg;
    logic [LVL_W-1:0]   res_tune_reg;
    logic               res_status_reg;
    logic               out_valid_reg;
    logic [LVL_W-1:0]   out_tune_reg;
    logic               out_status_reg;
    logic               out_wp_reg;
    logic [LVL_W-1:0]   last_tune_reg;

    logic [QUO_W-1:0]   div_quo;
    logic               div_done;

    // Table lookup: top entry is point_max, extras repeat point_default
    function automatic logic [POINT_W-1:0] entry_of(
        input logic [IDX_W-1:0] i,
        input logic [POINT_W-1:0] regs [NUM_POINT_REGS]
    );
        logic [POINT_W-1:0] e;
        if (int'(i) >= NUM_POINTS - 1)
            e = regs[TOP];
        else if (int'(i) > TOP - 1)
            e = regs[TOP-1];
        else
            e = regs[REG_IDX_W'(i)];
        return e;
    endfunction

    logic [POINT_W-1:0] entry;
    logic [BRI_W-1:0]   e_bri;
    logic [LVL_W-1:0]   e_lvl;
    logic [BRI_W-1:0]   p_bri;
    logic [LVL_W-1:0]   p_lvl;
    logic [BRI_W-1:0]   top_bri;
    logic               hit;
    logic               lvl_fall;
    logic               out_free;

    assign entry    = entry_of(idx_reg, point_reg);
    assign e_bri    = entry[BRI_W-1:0];
    assign e_lvl    = entry[POINT_W-1:BRI_W];
    assign p_bri    = prev_reg[BRI_W-1:0];
    assign p_lvl    = prev_reg[POINT_W-1:BRI_W];
    assign top_bri  = point_reg[TOP][BRI_W-1:0];
    assign hit      = (b_reg <= e_bri) || (idx_reg == IDX_W'(NUM_POINTS - 1));
    assign lvl_fall = e_lvl < p_lvl;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Configuration write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_POINT_REGS; k++)
                point_reg[k] <= '0;
            outdoor_tune_reg <= '0;
            hbm_mode_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POINT_OFF,
                REG_POINT_MIN,
                REG_POINT_DIM,
                REG_POINT_DEFAULT,
                REG_POINT_MAX:    point_reg[cfg_index] <= cfg_wdata[POINT_W-1:0];
                REG_OUTDOOR_TUNE: outdoor_tune_reg     <= cfg_wdata[LVL_W-1:0];
                REG_HBM_MODE:     hbm_mode_reg         <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    // Sequencer with registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            b_reg          <= '0;
            idx_reg        <= '0;
            prev_reg       <= '0;
            hi_lvl_reg     <= '0;
            mul_a_reg      <= '0;
            mag_reg        <= '0;
            neg_reg        <= 1'b0;
            den_reg        <= '0;
            prod_reg       <= '0;
            div_start_reg  <= 1'b0;
            res_tune_reg   <= '0;
            res_status_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_tune_reg   <= '0;
            out_status_reg <= 1'b0;
            out_wp_reg     <= 1'b0;
            last_tune_reg  <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;

            // Output valid: set on load, cleared on transfer
            if ((state_reg == ST_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        b_reg     <= s_axis_tuser ? s_axis_tdata : '0;
                        state_reg <= ST_CHECK;
                    end
                end

                // Range check and high-brightness shortcut
                ST_CHECK:
                begin
                    idx_reg  <= '0;
                    prev_reg <= '0;
                    if (b_reg > top_bri)
                    begin
                        res_tune_reg   <= '0;
                        res_status_reg <= 1'b1;
                        state_reg      <= ST_DONE;
                    end
                    else if (hbm_mode_reg && (b_reg == top_bri))
                    begin
                        res_tune_reg   <= outdoor_tune_reg;
                        res_status_reg <= 1'b0;
                        state_reg      <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_SEARCH;
                    end
                end

                // One breakpoint compare per cycle
                ST_SEARCH:
                begin
                    if (!hit)
                    begin
                        prev_reg <= entry;
                        idx_reg  <= idx_reg + IDX_W'(1);
                    end
                    else if (idx_reg <= IDX_W'(1))
                    begin
                        res_tune_reg   <= e_lvl;
                        res_status_reg <= 1'b0;
                        state_reg      <= ST_DONE;
                    end
                    else
                    begin
                        hi_lvl_reg <= e_lvl;
                        mul_a_reg  <= e_bri - b_reg;
                        neg_reg    <= lvl_fall;
                        mag_reg    <= lvl_fall ? (p_lvl - e_lvl) : (e_lvl - p_lvl);
                        den_reg    <= e_bri - p_bri;
                        state_reg  <= ST_MUL;
                    end
                end

                ST_MUL:
                begin
                    prod_reg      <= DIVIDEND_W'(mul_a_reg * mag_reg);
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_DIV;
                end

                // Offset truncates toward zero: apply the sign to the magnitude
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        res_tune_reg   <= neg_reg ? (hi_lvl_reg + div_quo)
                                                  : (hi_lvl_reg - div_quo);
                        res_status_reg <= 1'b0;
                        state_reg      <= ST_DONE;
                    end
                end

                // Load the output register once it is free
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_tune_reg   <= res_tune_reg;
                        out_status_reg <= res_status_reg;
                        out_wp_reg     <= !res_status_reg && (res_tune_reg != last_tune_reg);
                        if (!res_status_reg)
                            last_tune_reg <= res_tune_reg;
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    bplm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tune_reg;
    assign m_axis_tuser  = {out_wp_reg, out_status_reg};

endmodule

`default_nettype wire

// ===== rtl/bplm_checker.sv =====
// ----------------------------------------------------------------------------
// bplm_checker
// Port-level checks for the brightness map unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "brightness_piecewise_linear_map_unit_macros.svh"

module bplm_checker
    import bplm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    input  wire logic             s_axis_tready,
    input  wire logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    input  wire logic [LVL_W-1:0] m_axis_tdata,
    input  wire logic [1:0]       m_axis_tuser
);

    // A stalled result holds its payload
    `BPLM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // An out-of-range result carries level zero and no panel write
    `BPLM_ASSERT_SAME(a_err_fields, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == '0) && !m_axis_tuser[1], "error result has nonzero fields")

    // One request at a time: input closes right after a transfer
    `BPLM_ASSERT_NEXT(a_one_inflight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready while busy")

    // A request never completes in the cycle after it is taken
    `BPLM_ASSERT_NEXT(a_min_latency, clk, rst_n, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid, "result too early")

endmodule

bind brightness_piecewise_linear_map_unit bplm_checker u_bplm_checker (.*);

`default_nettype wire
